// ===== rtl/lsm_pkg.sv =====
// Shared types, constants and helpers for the layer stack manager.
// No dependencies; every other file in rtl/ imports this package.
package lsm_pkg;

  // Stack geometry and code layout
  localparam int STACK_DEPTH  = 16;
  localparam int SHIFT_OFFSET = 42;
  localparam int MOVE_OFFSET  = 84;
  localparam int NEXT_CODE    = 34;
  localparam int PREV_CODE    = 33;
  localparam int MAX_LAYERS   = 32;

  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W   = $clog2(STACK_DEPTH);
  localparam int DL_W    = 6;
  localparam int LAYER_W = 5;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_DEFINED_LAYERS = 1'b0;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       is_mod_layer;
    logic       toggled_on;
  } key_req_t;

  typedef struct packed {
    logic               stack_changed;
    logic               mask_key;
    logic               remap_key;
    logic [LAYER_W-1:0] remap_layer;
    logic [LAYER_W-1:0] stack_depth;
    logic [LAYER_W-1:0] active_layer;
  } layer_result_t;

  typedef enum logic [1:0] {
    ACT_MOVE,
    ACT_STEP,
    ACT_SHIFT,
    ACT_LOCK
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOP,
    S_PLAN,
    S_SCAN,
    S_RESOLVE,
    S_EVICT,
    S_WRITE,
    S_FINAL,
    S_DONE
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic rd_top;
    logic scan_clear;
    logic scan_step;
    logic set_mask;
    logic set_step;
    logic move;
    logic move_zero;
    logic drop;
    logic drop_zero;
    logic write;
    logic finish;
  } lsm_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    act_t act;
    logic on;
    logic move_ok;
    logic step_ok;
    logic push_ok;
    logic zero_ok;
    logic single;
    logic full;
    logic scan_last;
    logic hit;
    logic want_pull;
  } lsm_stat_t;

  // Strip the shift offset from a stack entry
  function automatic logic [7:0] plain_layer(input logic [7:0] v);
    return (v >= 8'(SHIFT_OFFSET)) ? v - 8'(SHIFT_OFFSET) : v;
  endfunction

endpackage

// ===== rtl/lsm_dpath.sv =====
// Datapath of the layer stack manager: stack registers, scan, drop and push.
// Depends on lsm_pkg; driven by lsm_ctrl through lsm_cmd_t.
module lsm_dpath
  import lsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  key_req_t          key_req,
  input  logic [DL_W-1:0]   defined_layers,
  input  lsm_cmd_t          cmd,
  output lsm_stat_t         stat,
  output layer_result_t     result
);

  logic [7:0]       stack [STACK_DEPTH];
  logic [CNT_W-1:0] count;
  act_t             act;
  logic             on;
  logic [7:0]       kc;
  logic [7:0]       val;
  logic [7:0]       top;
  logic [7:0]       lk_val;
  logic             lk_found;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] hit_pos;
  logic             hit;
  logic             mask;
  logic             remap;
  logic             changed;
  logic [LAYER_W-1:0] remap_layer;

  logic [7:0]       kc_in;
  act_t             act_in;
  logic [7:0]       shift_rel;
  logic [IDX_W-1:0] top_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic [7:0]       top_plain;
  logic [7:0]       tgt;
  logic [7:0]       move_layer;
  logic [7:0]       dl8;
  logic [IDX_W-1:0] drop_pos;

  // Decode the incoming key
  always_comb begin
    kc_in = key_req.is_mod_layer ? 8'(key_req.key_byte[7:3]) + 8'(SHIFT_OFFSET)
                                 : key_req.key_byte;
    shift_rel = kc_in - 8'(SHIFT_OFFSET);
    if (kc_in >= 8'(MOVE_OFFSET)) begin
      act_in = ACT_MOVE;
    end else if (kc_in >= 8'(SHIFT_OFFSET)) begin
      if (shift_rel == 8'(NEXT_CODE) || shift_rel == 8'(PREV_CODE)) begin
        act_in = ACT_STEP;
      end else begin
        act_in = ACT_SHIFT;
      end
    end else begin
      act_in = ACT_LOCK;
    end
  end

  // One read port over the stack: scan index or top of stack
  always_comb begin
    top_addr   = IDX_W'(count - CNT_W'(1));
    rd_addr    = cmd.scan_step ? idx : top_addr;
    rd_data    = stack[rd_addr];
    top_plain  = plain_layer(top);
    tgt        = (kc == 8'(SHIFT_OFFSET + NEXT_CODE)) ? top_plain + 8'd1 : top_plain - 8'd1;
    move_layer = kc - 8'(MOVE_OFFSET);
    dl8        = 8'(defined_layers);
    drop_pos   = cmd.drop_zero ? '0 : hit_pos;
  end

  always_comb begin
    stat.act       = act;
    stat.on        = on;
    stat.move_ok   = move_layer < dl8;
    stat.step_ok   = tgt < dl8;
    stat.push_ok   = plain_layer(val) < dl8;
    stat.zero_ok   = defined_layers != '0;
    stat.single    = count <= CNT_W'(1);
    stat.full      = count >= CNT_W'(STACK_DEPTH);
    stat.scan_last = (CNT_W'(idx) + CNT_W'(1)) == count;
    stat.hit       = hit;
    stat.want_pull = (act == ACT_SHIFT && !on) ||
                     (act == ACT_LOCK && lk_found && lk_val == kc);
  end

  // Stack entries: move writes the bottom, drop shifts down, push writes at count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < STACK_DEPTH; j++) begin
        stack[j] <= 8'd0;
      end
    end else begin
      if (cmd.move) begin
        stack[0] <= cmd.move_zero ? 8'd0 : move_layer;
      end
      if (cmd.drop) begin
        for (int j = 0; j < STACK_DEPTH - 1; j++) begin
          if (IDX_W'(j) >= drop_pos) begin
            stack[j] <= stack[j+1];
          end
        end
      end
      if (cmd.write) begin
        stack[IDX_W'(count)] <= val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= CNT_W'(1);
      act      <= ACT_MOVE;
      on       <= 1'b0;
      hit      <= 1'b0;
      lk_found <= 1'b0;
      idx      <= '0;
      mask     <= 1'b0;
      remap    <= 1'b0;
      changed  <= 1'b0;
    end else begin
      if (cmd.load) begin
        act     <= act_in;
        on      <= key_req.toggled_on;
        mask    <= 1'b0;
        remap   <= 1'b0;
        changed <= 1'b0;
      end
      if (cmd.scan_clear) begin
        idx      <= '0;
        hit      <= 1'b0;
        lk_found <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (rd_data == val && !hit) begin
          hit <= 1'b1;
        end
        if (rd_data < 8'(SHIFT_OFFSET)) begin
          lk_found <= 1'b1;
        end
        idx <= idx + IDX_W'(1);
      end
      if (cmd.set_mask) begin
        mask <= 1'b1;
      end
      if (cmd.set_step) begin
        remap <= 1'b1;
      end
      if (cmd.move) begin
        count   <= CNT_W'(1);
        changed <= 1'b1;
      end
      if (cmd.drop) begin
        count   <= count - CNT_W'(1);
        changed <= 1'b1;
      end
      if (cmd.write) begin
        count   <= count + CNT_W'(1);
        changed <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kc          <= kc_in;
      val         <= kc_in;
      remap_layer <= '0;
    end
    if (cmd.set_step) begin
      val         <= tgt + 8'(SHIFT_OFFSET);
      remap_layer <= LAYER_W'(tgt);
    end
    if (cmd.scan_step) begin
      if (rd_data == val && !hit) begin
        hit_pos <= idx;
      end
      if (rd_data < 8'(SHIFT_OFFSET)) begin
        lk_val <= rd_data;
      end
    end
    if (cmd.rd_top) begin
      top <= rd_data;
    end
    if (cmd.finish) begin
      result.stack_changed <= changed;
      result.mask_key      <= mask;
      result.remap_key     <= remap;
      result.remap_layer   <= remap_layer;
      result.stack_depth   <= LAYER_W'(count);
      result.active_layer  <= LAYER_W'(plain_layer(rd_data));
    end
  end

endmodule

// ===== rtl/lsm_ctrl.sv =====
// Controller of the layer stack manager: sequences decode, scan and update.
// Depends on lsm_pkg; commands lsm_dpath, reads its status.
module lsm_ctrl
  import lsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  lsm_stat_t stat,
  output lsm_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_TOP;
      end
      S_TOP: state_next = S_PLAN;
      S_PLAN: begin
        state_next = S_FINAL;
        unique case (stat.act)
          ACT_MOVE:  state_next = S_FINAL;
          ACT_STEP:  if (stat.on && stat.step_ok) state_next = S_SCAN;
          ACT_SHIFT: state_next = S_SCAN;
          ACT_LOCK:  if (stat.on) state_next = S_SCAN;
        endcase
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        priority if (stat.want_pull) begin
          state_next = S_FINAL;
        end else if (!stat.push_ok || (stat.act == ACT_SHIFT && stat.hit)) begin
          state_next = S_FINAL;
        end else begin
          state_next = S_EVICT;
        end
      end
      S_EVICT: state_next = S_WRITE;
      S_WRITE: state_next = S_FINAL;
      S_FINAL: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = state != S_IDLE;
    done = state == S_DONE;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_TOP: begin
        cmd.rd_top = 1'b1;
      end
      S_PLAN: begin
        cmd.scan_clear = 1'b1;
        unique case (stat.act)
          ACT_MOVE:  cmd.move = stat.on && stat.move_ok;
          ACT_STEP: begin
            cmd.set_mask = stat.on && !stat.step_ok;
            cmd.set_step = stat.on && stat.step_ok;
          end
          ACT_SHIFT: cmd.move = 1'b0;
          ACT_LOCK:  cmd.move = 1'b0;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_RESOLVE: begin
        priority if (stat.want_pull) begin
          if (stat.hit) begin
            if (stat.single) begin
              cmd.move      = stat.zero_ok;
              cmd.move_zero = 1'b1;
            end else begin
              cmd.drop = 1'b1;
            end
          end
        end else if (stat.push_ok && stat.act != ACT_SHIFT) begin
          cmd.drop = stat.hit;
        end else begin
          cmd.drop = 1'b0;
        end
      end
      S_EVICT: begin
        cmd.drop      = stat.full;
        cmd.drop_zero = 1'b1;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
      end
      S_DONE: begin
        cmd.load = 1'b0;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/layer_stack_manager.sv =====
// Top level of the layer stack manager: APB register, controller, datapath.
// Depends on lsm_pkg, lsm_ctrl and lsm_dpath.
//
// Usage:
//   Raise start with a layer-key request on key_req; the request is taken at
//   the rising edge where start is high and busy is low. busy then stays high
//   until the result has been shown. The result appears on result for exactly
//   one cycle, marked by done; the receiver must take it in that cycle, it
//   cannot stall the block.
//   A request that pushes passes through S_TOP, S_PLAN, a scan of the active
//   layers, S_RESOLVE, S_EVICT, S_WRITE, S_FINAL and S_DONE. A request that
//   only removes a layer, or finds it already active, skips S_EVICT and
//   S_WRITE. A request that needs no stack search (move, released lock or
//   next/previous, masked next/previous) skips the scan and S_RESOLVE as well.
//   The scan reads the stack registers linearly, one entry per cycle. busy
//   falls in the cycle after done, so the block takes no new request until
//   the result of the last one has been shown.
//   defined_layers sits at byte address 0 of the APB port; writes whose low
//   six bits exceed 32 saturate to 32. Write it only while busy is low.
//   Reset (rst, synchronous) leaves one active layer, layer 0, with
//   defined_layers set to 1.
module layer_stack_manager
  import lsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  key_req_t          key_req,
  output logic              done,
  output layer_result_t     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [DL_W-1:0] defined_layers;
  logic [DL_W-1:0] wr_val;
  logic            reg_wr;
  lsm_cmd_t        cmd;
  lsm_stat_t       stat;

  // Configuration register: zero wait states, saturate writes at MAX_LAYERS
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_DEFINED_LAYERS);
  assign wr_val = (pwdata[DL_W-1:0] > DL_W'(MAX_LAYERS)) ? DL_W'(MAX_LAYERS)
                                                          : pwdata[DL_W-1:0];
  assign prdata = (paddr[2] == REG_DEFINED_LAYERS) ? APB_DW'(defined_layers) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      defined_layers <= DL_W'(1);
    end else if (reg_wr) begin
      defined_layers <= wr_val;
    end
  end

  // Sequence each request; the datapath holds the stack and the result
  lsm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lsm_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .key_req        (key_req),
    .defined_layers (defined_layers),
    .cmd            (cmd),
    .stat           (stat),
    .result         (result)
  );

  // An accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A masked key never changes the stack
  a_mask_quiet: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.mask_key && result.stack_changed))
    else $error("mask_key together with stack_changed");

  // A remap always pushes a layer
  a_remap_push: assert property (@(posedge clk) disable iff (rst)
    (done && result.remap_key) |-> result.stack_changed)
    else $error("remap_key without stack change");

  // The result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

endmodule

// ===== tb/sv/layer_stack_checker.sv =====
// Checker for the layer stack manager: tracks the layer stack and scores each result.
// Depends on lsm_pkg. Watches the request, result and APB channels; drives only its counters.
module layer_stack_checker
  import lsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  key_req_t          key_req,
  input  logic              done,
  input  layer_result_t     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic [APB_DW-1:0] prdata,
  input  logic              pready,
  output int                errors,
  output int                outstanding,
  output int                checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]    stack_entry [STACK_DEPTH];
  int unsigned   stack_len;
  int unsigned   layer_limit;
  bit            stack_touched;
  layer_result_t expected_results [$];
  layer_result_t want;

  initial begin
    errors      = 0;
    outstanding = 0;
    checked     = 0;
  end

  function automatic int unsigned unshift(int unsigned v);
    return (v >= SHIFT_OFFSET) ? v - SHIFT_OFFSET : v;
  endfunction

  function automatic int unsigned top_value();
    if (stack_len == 0 || stack_len > STACK_DEPTH) return 0;
    return stack_entry[stack_len-1];
  endfunction

  function automatic int locate(int unsigned v);
    for (int unsigned i = 0; i < stack_len && i < STACK_DEPTH; i++)
      if (stack_entry[i] == v) return int'(i);
    return -1;
  endfunction

  function automatic void remove_at(int unsigned pos);
    if (pos >= stack_len || stack_len > STACK_DEPTH) return;
    for (int unsigned i = pos; i + 1 < stack_len; i++)
      stack_entry[i] = stack_entry[i+1];
    stack_len--;
  endfunction

  function automatic void jump_to(int unsigned layer);
    if (layer >= layer_limit) return;
    stack_len      = 1;
    stack_entry[0] = 8'(layer);
    stack_touched  = 1'b1;
  endfunction

  function automatic void activate(int unsigned v);
    int pos;
    if (unshift(v) >= layer_limit) return;
    pos = locate(v);
    if (pos >= 0) remove_at(pos);
    while (stack_len >= STACK_DEPTH) remove_at(0);
    stack_entry[stack_len] = 8'(v);
    stack_len++;
    stack_touched = 1'b1;
  endfunction

  function automatic void deactivate(int unsigned v);
    int pos;
    pos = locate(v);
    if (pos < 0) return;
    if (stack_len <= 1) begin
      jump_to(0);
      return;
    end
    remove_at(pos);
    stack_touched = 1'b1;
  endfunction

  // Apply one layer-key request to the tracked stack and form its result.
  function automatic layer_result_t apply_key(key_req_t req);
    layer_result_t r;
    int unsigned   kc;
    int unsigned   t;
    int unsigned   tgt;
    int unsigned   locked;
    bit            found;
    r             = '0;
    stack_touched = 1'b0;
    kc            = req.key_byte;
    if (req.is_mod_layer) kc = kc / 8 + SHIFT_OFFSET;
    if (kc >= MOVE_OFFSET) begin
      if (req.toggled_on) jump_to(kc - MOVE_OFFSET);
    end else if (kc >= SHIFT_OFFSET) begin
      t = kc - SHIFT_OFFSET;
      if (t == NEXT_CODE || t == PREV_CODE) begin
        if (req.toggled_on) begin
          tgt = (t == NEXT_CODE) ? unshift(top_value()) + 1 : unshift(top_value()) - 1;
          tgt = tgt & 8'hFF;
          if (tgt >= layer_limit) begin
            r.mask_key = 1'b1;
          end else begin
            activate(tgt + SHIFT_OFFSET);
            r.remap_key   = 1'b1;
            r.remap_layer = LAYER_W'(tgt);
          end
        end
      end else if (req.toggled_on) begin
        if (locate(kc) < 0) activate(kc);
      end else begin
        deactivate(kc);
      end
    end else if (req.toggled_on) begin
      found  = 1'b0;
      locked = 0;
      for (int unsigned i = 0; i < stack_len && i < STACK_DEPTH; i++) begin
        if (stack_entry[i] < SHIFT_OFFSET) begin
          locked = stack_entry[i];
          found  = 1'b1;
        end
      end
      if (found && locked == kc) deactivate(kc);
      else activate(kc);
    end
    r.stack_changed = stack_touched;
    r.stack_depth   = LAYER_W'(stack_len);
    r.active_layer  = LAYER_W'(unshift(top_value()));
    return r;
  endfunction

  task automatic flag_result(string what, layer_result_t exp_r, layer_result_t got_r);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: expected chg=%0d mask=%0d remap=%0d/%0d depth=%0d top=%0d",
               $realtime, what, exp_r.stack_changed, exp_r.mask_key, exp_r.remap_key,
               exp_r.remap_layer, exp_r.stack_depth, exp_r.active_layer);
      $display("    got chg=%0d mask=%0d remap=%0d/%0d depth=%0d top=%0d",
               got_r.stack_changed, got_r.mask_key, got_r.remap_key, got_r.remap_layer,
               got_r.stack_depth, got_r.active_layer);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (stack_entry[i]) stack_entry[i] = '0;
      stack_len   = 1;
      layer_limit = 1;
      expected_results.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == REG_DEFINED_LAYERS) begin
        if (pwrite) begin
          layer_limit = (pwdata[DL_W-1:0] > MAX_LAYERS) ? MAX_LAYERS : pwdata[DL_W-1:0];
        end else if (prdata !== APB_DW'(layer_limit)) begin
          errors++;
          if (errors <= 10)
            $display("%0t defined_layers read: expected %0d, got %0h",
                     $realtime, layer_limit, prdata);
        end
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          flag_result("result with nothing expected", '0, result);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (result.stack_changed !== want.stack_changed ||
              result.mask_key !== want.mask_key ||
              result.remap_key !== want.remap_key ||
              result.remap_layer !== want.remap_layer ||
              result.stack_depth !== want.stack_depth ||
              result.active_layer !== want.active_layer)
            flag_result("result mismatch", want, result);
        end
      end
      if (start && !busy) expected_results.push_back(apply_key(key_req));
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== tb/sv/tb_layer_stack_manager.sv =====
// Top of the layer stack manager testbench: clock, reset, request and APB stimulus, verdict.
// Depends on lsm_pkg, the layer_stack_manager RTL and layer_stack_checker.
module tb_layer_stack_manager;
  import lsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with neither a request nor a result taken before the run is declared hung.
  // Worst honest gap: the longest sender pause plus a full-stack request.
  localparam int HANG_LIMIT = 2000;
  localparam logic [APB_AW-1:0] LAYERS_ADDR = {REG_DEFINED_LAYERS, 2'b00};

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  key_req_t          key_req;
  logic              done;
  layer_result_t     result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int          chk_errors;
  int          chk_outstanding;
  int          chk_checked;
  int          sent;
  int          results_seen;
  int          hang_count;
  int          settings_used;
  int          deepest;
  int          idle_pct;
  int unsigned layer_span;
  int unsigned held_shifts [$];
  int          layer_plan [8];

  layer_stack_manager dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .key_req (key_req),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  layer_stack_checker chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .key_req     (key_req),
    .done        (done),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .errors      (chk_errors),
    .outstanding (chk_outstanding),
    .checked     (chk_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Count results and note the deepest stack seen; nonblocking so the stimulus
  // process always reads the value from before the edge.
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (int'(result.stack_depth) > deepest) deepest <= int'(result.stack_depth);
    end
  end

  // Watchdog: reset the count whenever a request or a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      hang_count <= 0;
    end else begin
      hang_count <= hang_count + 1;
      if (hang_count >= HANG_LIMIT) begin
        $display("watchdog: no request or result taken for %0d cycles", HANG_LIMIT);
        $display("tb_layer_stack_manager: errors");
        $finish;
      end
    end
  end

  // Offer one request, after an optional random pause, and hold it until taken.
  // start is left high on acceptance so a following request can ride straight on.
  task automatic send_key(input logic [7:0] kc, input logic mod, input logic on);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    start   <= 1'b1;
    key_req <= '{key_byte: kc, is_mod_layer: mod, toggled_on: on};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Drop start and hold until every request taken has produced its result.
  task automatic wait_drained();
    start <= 1'b0;
    while (results_seen != sent || busy) @(posedge clk);
    @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready. psel stays up so
  // transfers can follow back to back; the caller lowers it.
  task automatic apb_xfer(input logic wr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LAYERS_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Change defined_layers only with the block idle, then read it back.
  task automatic set_layers(input int value);
    wait_drained();
    apb_xfer(1'b1, APB_DW'(value));
    apb_xfer(1'b0, '0);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    layer_span = (value > MAX_LAYERS) ? MAX_LAYERS : value;
    settings_used++;
  endtask

  // Build one random request. Most are well-formed press/release pairs on
  // layers that exist, so the stack fills and evicts; the rest is noise.
  task automatic random_key(output logic [7:0] kc, output logic mod, output logic on);
    int          pick;
    int unsigned lyr;
    int unsigned slot;
    pick = $urandom_range(0, 99);
    lyr  = $urandom_range(0, layer_span);
    mod  = 1'b0;
    on   = 1'b1;
    if (pick < 30) begin
      // shift press; remember it so a release can follow later
      kc = 8'(SHIFT_OFFSET + lyr);
      held_shifts.push_back(lyr);
    end else if (pick < 50) begin
      on = 1'b0;
      if (held_shifts.size() > 0) begin
        slot = $urandom_range(0, held_shifts.size() - 1);
        kc   = 8'(SHIFT_OFFSET + held_shifts[slot]);
        held_shifts.delete(slot);
      end else begin
        kc = 8'($urandom_range(SHIFT_OFFSET, MOVE_OFFSET - 1));
      end
    end else if (pick < 62) begin
      kc = 8'(lyr);
      on = ($urandom_range(0, 9) != 0);
    end else if (pick < 70) begin
      kc = 8'(MOVE_OFFSET + lyr);
      on = ($urandom_range(0, 7) != 0);
    end else if (pick < 82) begin
      kc = 8'(SHIFT_OFFSET + ($urandom_range(0, 1) ? NEXT_CODE : PREV_CODE));
      on = ($urandom_range(0, 5) != 0);
    end else if (pick < 90) begin
      // mod-layer key: the code byte carries the layer in its upper five bits
      if (lyr > 31) lyr = 31;
      kc  = 8'(lyr * 8 + $urandom_range(0, 7));
      mod = 1'b1;
      on  = 1'($urandom_range(0, 1));
    end else begin
      kc  = 8'($urandom_range(0, 255));
      mod = 1'($urandom_range(0, 1));
      on  = 1'($urandom_range(0, 1));
    end
  endtask

  initial begin
    logic [7:0] kc;
    logic       mod;
    logic       on;
    rst           = 1'b1;
    start         = 1'b0;
    key_req       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    sent          = 0;
    results_seen  = 0;
    hang_count    = 0;
    settings_used = 1;
    deepest       = 0;
    idle_pct      = 0;
    layer_span    = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Reset leaves only layer 0 defined.
    send_key(8'(SHIFT_OFFSET + PREV_CODE), 1'b0, 1'b1);  // previous from layer 0: wraps, masked
    send_key(8'(SHIFT_OFFSET + NEXT_CODE), 1'b0, 1'b1);  // next past the last layer: masked
    set_layers(MAX_LAYERS);
    send_key(8'(MOVE_OFFSET + 1), 1'b0, 1'b0);           // released move does nothing
    send_key(8'(MOVE_OFFSET + 3), 1'b0, 1'b1);           // move to layer 3
    send_key(8'd5, 1'b0, 1'b1);                          // lock 5 on
    send_key(8'd5, 1'b0, 1'b1);                          // lock 5 again: toggles off
    send_key(8'd5, 1'b0, 1'b0);                          // released lock does nothing
    send_key(8'(SHIFT_OFFSET + NEXT_CODE), 1'b0, 1'b1);  // next from 3: remap to 4
    send_key(8'(SHIFT_OFFSET + PREV_CODE), 1'b0, 1'b1);  // previous from 4: remap to 3
    send_key(8'(SHIFT_OFFSET + 7), 1'b0, 1'b1);          // shift 7 press
    send_key(8'(SHIFT_OFFSET + 7), 1'b0, 1'b1);          // shift 7 held: already active
    send_key(8'(SHIFT_OFFSET + 7), 1'b0, 1'b0);          // shift 7 release
    send_key(8'd80, 1'b1, 1'b1);                         // mod-layer key on layer 10
    send_key(8'd255, 1'b0, 1'b1);                        // move far beyond any layer
    send_key(8'd255, 1'b1, 1'b1);                        // mod-layer key on layer 31
    send_key(8'(MOVE_OFFSET), 1'b0, 1'b1);               // move to 0
    send_key(8'(SHIFT_OFFSET + 1), 1'b0, 1'b1);          // shift 1 over locked 0
    send_key(8'd0, 1'b0, 1'b1);                          // unlock 0: only a shifted entry left
    send_key(8'd7, 1'b0, 1'b1);                          // lock with no unshifted entry
    send_key(8'(MOVE_OFFSET), 1'b0, 1'b1);               // move to 0
    send_key(8'd0, 1'b0, 1'b1);                          // unlock the only layer: back to 0
    set_layers(0);
    send_key(8'd0, 1'b0, 1'b1);                          // only layer, nothing defined: no change
    send_key(8'(SHIFT_OFFSET), 1'b0, 1'b1);              // shift onto an undefined layer
    send_key(8'd0, 1'b1, 1'b0);                          // mod-layer release, nothing held

    // Random part: one defined_layers setting per phase, idling varied by phase.
    layer_plan = '{MAX_LAYERS, 63, 8, 0, 1, 40, 16, MAX_LAYERS};
    layer_plan[6] = $urandom_range(2, 31);
    for (int ph = 0; ph < 8; ph++) begin
      set_layers(layer_plan[ph]);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 56;
        default: idle_pct = 25;
      endcase
      held_shifts.delete();
      for (int n = 0; n < 60; n++) begin
        // pause now and then until the block has answered everything
        if ((ph == 1 && n == 30) || $urandom_range(0, 59) == 0) wait_drained();
        random_key(kc, mod, on);
        send_key(kc, mod, on);
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    $display("covered %0d key requests over %0d defined_layers settings; %0d results checked",
             sent, settings_used, chk_checked);
    $display("deepest stack reached %0d of %0d entries", deepest, STACK_DEPTH);
    if (chk_errors == 0 && chk_outstanding == 0) begin
      $display("tb_layer_stack_manager: clean");
    end else begin
      $display("mismatches %0d, results still expected %0d", chk_errors, chk_outstanding);
      $display("tb_layer_stack_manager: errors");
    end
    $finish;
  end

endmodule
